// File: rtl/arx_pkg.sv
// ----------------------------------------------------------------------------
// arx_pkg
// Shared types, constants and round helpers for the ARX CBC cipher block.
// ----------------------------------------------------------------------------
package arx_pkg;

  localparam int ROUND_COUNT = 64;
  localparam int RK_AW       = $clog2(ROUND_COUNT);
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd6;

  localparam logic [31:0] SEED_0 = 32'hb5232c67;
  localparam logic [31:0] SEED_1 = 32'habdd2f50;
  localparam logic [31:0] SEED_2 = 32'hab790aaa;
  localparam logic [31:0] SEED_3 = 32'he8395ac0;

  typedef logic [3:0][31:0] quad_t;  // element 0 is word 0

  typedef struct packed {
    logic [31:0] in_word_0;
    logic [31:0] in_word_1;
    logic [31:0] in_word_2;
    logic [31:0] in_word_3;
    logic        first_block;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word_0;
    logic [31:0] out_word_1;
    logic [31:0] out_word_2;
    logic [31:0] out_word_3;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             sched_start;  // seed schedule registers from the key
    logic             sched_step;   // one mixing iteration, write round key
    logic [RK_AW-1:0] sched_addr;
    logic [1:0]       sched_phase;  // (r-1) & 3
    logic             load;         // take input item, apply chain
    logic             round;        // one cipher round
    logic [RK_AW-1:0] rk_addr;      // round key read address
    logic             finish;       // final xor, chain update, output
  } dp_cmd_t;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: rtl/arx_ctrl.sv
// ----------------------------------------------------------------------------
// arx_ctrl
// Sequencer: key schedule build, then per item load, 64 rounds, finish.
// ----------------------------------------------------------------------------
module arx_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            key_write,
  input  logic            cfg_valid,
  output logic            idle,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_busy,
  output arx_pkg::dp_cmd_t cmd
);
  import arx_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCHED, S_RDK, S_ROUND, S_FIN} state_t;

  state_t           state_r;
  logic             built_r;
  logic [RK_AW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      built_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (key_write || (in_valid && !built_r)) begin
            state_r <= S_SCHED;
            cnt_r   <= RK_AW'(1);
          end else if (in_valid && in_ready) begin
            state_r <= S_RDK;
            cnt_r   <= '0;
          end
        end
        S_SCHED: begin
          if (cnt_r == RK_AW'(ROUND_COUNT - 2)) begin
            built_r <= 1'b1;
            state_r <= S_IDLE;
          end
          cnt_r <= cnt_r + 1'b1;
        end
        S_RDK: begin
          state_r <= S_ROUND;
          cnt_r   <= cnt_r + 1'b1;
        end
        S_ROUND: begin
          if (cnt_r == '0) state_r <= S_FIN;
          cnt_r <= cnt_r + 1'b1;
        end
        S_FIN: begin
          // hold here while the previous result is still waiting
          if (!out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    idle            = (state_r == S_IDLE);
    in_ready        = idle && built_r && !cfg_valid;
    cmd.sched_start = idle && (key_write || (in_valid && !built_r));
    cmd.sched_step  = (state_r == S_SCHED);
    cmd.sched_addr  = cnt_r;
    cmd.sched_phase = 2'(cnt_r - 1'b1);
    cmd.load        = in_valid && in_ready;
    cmd.rk_addr     = cnt_r;
    cmd.round       = (state_r == S_ROUND);
    cmd.finish      = (state_r == S_FIN) && !out_busy;
  end

endmodule

// File: rtl/arx_datapath.sv
// ----------------------------------------------------------------------------
// arx_datapath
// Key schedule mixer, round key memory, round unit and CBC chaining.
// ----------------------------------------------------------------------------
module arx_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  arx_pkg::dp_cmd_t  cmd,
  input  logic [255:0]      key,
  input  logic [127:0]      iv,
  input  logic              decrypt,
  input  arx_pkg::in_item_t in_item,
  output arx_pkg::quad_t    result
);
  import arx_pkg::*;

  quad_t ks_s_r, ks_t_r, blk_r, chain_r, saved_r, rk_r, res_r;
  quad_t rk_mem [ROUND_COUNT];
  quad_t key63, s_n, t_n, blk_n;
  logic  dec_r;

  // rebuild words explicitly: key[255:224] is key word 0
  quad_t k0w, k63w;
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      k0w[j]  = key[255 - 32*j -: 32];
      k63w[j] = key[127 - 32*j -: 32];
    end
  end
  assign key63 = k63w;

  // one mixing iteration, phase p = (r-1)&3
  always_comb begin
    quad_t s, t;
    logic [1:0] i0, i1, i2, i3;
    s  = ks_s_r;
    t  = ks_t_r;
    i0 = cmd.sched_phase;
    i1 = i0 + 2'd1;
    i2 = i0 + 2'd2;
    i3 = i0 + 2'd3;
    s[i0] = s[i0] ^ (rol(t[i0], 6)  + rol(s[i3], 5));
    s[i1] = s[i1] ^ (rol(t[i1], 10) + rol(s[i2], 9));
    s[i2] = s[i2] ^ (rol(t[i2], 7)  + rol(s[i0], 6));
    s[i3] = s[i3] ^ (rol(t[i3], 12) + rol(s[i1], 11));
    t[i0] = t[i0] ^ (rol(s[i0], 6)  + rol(t[i3], 5));
    t[i1] = t[i1] ^ (rol(s[i1], 10) + rol(t[i0], 9));
    t[i2] = t[i2] ^ (rol(s[i2], 7)  + rol(t[i1], 6));
    t[i3] = t[i3] ^ (rol(s[i3], 12) + rol(t[i2], 11));
    s_n = s;
    t_n = t;
  end

  // one cipher round
  always_comb begin
    quad_t s;
    s = blk_r;
    if (!dec_r) begin
      s[1] = rol(s[1] + s[2], 5) ^ s[0] ^ rk_r[1];
      s[2] = rol(s[2] + s[1], 9) ^ s[3] ^ rk_r[2];
      s[0] = ror(s[0] + s[2], 6) ^ s[3] ^ rk_r[0];
      s[3] = ror(s[3] + s[0], 11) ^ s[1] ^ rk_r[3];
    end else begin
      s[3] = rol(s[3] ^ rk_r[3] ^ s[1], 11) - s[0];
      s[0] = rol(s[0] ^ rk_r[0] ^ s[3], 6) - s[2];
      s[2] = ror(s[2] ^ rk_r[2] ^ s[3], 9) - s[1];
      s[1] = ror(s[1] ^ rk_r[1] ^ s[0], 5) - s[2];
    end
    blk_n = s;
  end

  // round key memory: write on schedule, registered read
  always_ff @(posedge clk) begin
    if (cmd.sched_start) begin
      rk_mem[0]               <= k0w;
      rk_mem[ROUND_COUNT - 1] <= key63;
    end else if (cmd.sched_step) begin
      rk_mem[cmd.sched_addr] <= s_n;
    end
    rk_r <= rk_mem[dec_r ? RK_AW'(ROUND_COUNT - 1) - cmd.rk_addr : cmd.rk_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.sched_start) begin
      ks_s_r <= {k0w[3] + SEED_3, k0w[2] + SEED_2, k0w[1] + SEED_1, k0w[0] + SEED_0};
      ks_t_r <= key63;
    end else if (cmd.sched_step) begin
      ks_s_r <= s_n;
      ks_t_r <= t_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (cmd.load) begin
      if (in_item.first_block) chain_r <= {iv[31:0], iv[63:32], iv[95:64], iv[127:96]};
    end else if (cmd.finish) begin
      chain_r <= dec_r ? saved_r : blk_r;
    end
  end

  always_ff @(posedge clk) begin
    quad_t c, x;
    if (cmd.load) begin
      c = in_item.first_block ? {iv[31:0], iv[63:32], iv[95:64], iv[127:96]} : chain_r;
      x = {in_item.in_word_3, in_item.in_word_2, in_item.in_word_1, in_item.in_word_0};
      dec_r   <= decrypt;
      saved_r <= x;
      blk_r   <= decrypt ? x : (x ^ c);
    end else if (cmd.round) begin
      blk_r <= blk_n;
    end
    if (cmd.finish) res_r <= dec_r ? (blk_r ^ chain_r) : blk_r;
  end

  assign result = res_r;

endmodule

// File: rtl/arx_block_cipher_cbc_top.sv
// ----------------------------------------------------------------------------
// arx_block_cipher_cbc_top
// 128-bit ARX block cipher, 256-bit key, 64 rounds, CBC encrypt and decrypt.
// ----------------------------------------------------------------------------
// From item accept, the first round key is fetched, then 64 rounds run
// from the round key memory, one per cycle, then finish.
// A new item is accepted only after the previous one has finished, and
// finish holds while the previous result is still waiting.
// A key write rebuilds the schedule with 62 mixing iterations.
// Synchronous active-low reset clears control, chain value and config
// registers; the round key memory is rebuilt before first use.
module arx_block_cipher_cbc_top #(
  parameter int CfgIdxW = arx_pkg::CFG_IDX_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  arx_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output arx_pkg::out_item_t  out_data
);
  import arx_pkg::*;

  logic [63:0] key_a_r, key_b_r, key_c_r, key_d_r, iv_hi_r, iv_lo_r;
  logic        dec_r;
  logic        out_valid_r;
  logic        key_write;
  logic        cfg_take;
  logic        ctrl_idle;
  dp_cmd_t     cmd;
  quad_t       result;

  // accept configuration writes only while the controller is idle
  assign cfg_ready = ctrl_idle;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign key_write = cfg_take && (cfg_index == CfgIdxW'(CFG_KEY_A) ||
                     cfg_index == CfgIdxW'(CFG_KEY_B) || cfg_index == CfgIdxW'(CFG_KEY_C) ||
                     cfg_index == CfgIdxW'(CFG_KEY_D));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0; key_b_r <= '0; key_c_r <= '0; key_d_r <= '0;
      iv_hi_r <= '0; iv_lo_r <= '0; dec_r <= 1'b0;
    end else if (cfg_take) begin
      case (cfg_index)
        CfgIdxW'(CFG_KEY_A):   key_a_r <= cfg_data;
        CfgIdxW'(CFG_KEY_B):   key_b_r <= cfg_data;
        CfgIdxW'(CFG_KEY_C):   key_c_r <= cfg_data;
        CfgIdxW'(CFG_KEY_D):   key_d_r <= cfg_data;
        CfgIdxW'(CFG_IV_HIGH): iv_hi_r <= cfg_data;
        CfgIdxW'(CFG_IV_LOW):  iv_lo_r <= cfg_data;
        CfgIdxW'(CFG_DECRYPT): dec_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the schedule start needs the written key value: feed it through now
  logic [255:0] key_now;
  always_comb begin
    key_now = {key_a_r, key_b_r, key_c_r, key_d_r};
    if (cfg_take) begin
      case (cfg_index)
        CfgIdxW'(CFG_KEY_A): key_now[255:192] = cfg_data;
        CfgIdxW'(CFG_KEY_B): key_now[191:128] = cfg_data;
        CfgIdxW'(CFG_KEY_C): key_now[127:64]  = cfg_data;
        CfgIdxW'(CFG_KEY_D): key_now[63:0]    = cfg_data;
        default: ;
      endcase
    end
  end

  arx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_write (key_write),
    .cfg_valid (cfg_valid),
    .idle      (ctrl_idle),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_busy  (out_valid_r),
    .cmd       (cmd)
  );

  arx_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .key     (key_now),
    .iv      ({iv_hi_r, iv_lo_r}),
    .decrypt (dec_r),
    .in_item (in_data),
    .result  (result)
  );

  // hold the result until taken; the next item waits at finish meanwhile
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign out_valid           = out_valid_r;
  assign out_data.out_word_0 = result[0];
  assign out_data.out_word_1 = result[1];
  assign out_data.out_word_2 = result[2];
  assign out_data.out_word_3 = result[3];

`ifndef SYNTH
  a_cfg_not_with_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> !(in_valid && in_ready))
    else $error("config write taken with an item");
  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r) else $error("finish did not raise out_valid");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("back-to-back accept");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while waiting");
`endif

endmodule
